/* src/assert_macros.svh */
// Assertion macros shared by the column gap filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ACGF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acgf assertion failed");

// Check that an expression holds at every clock edge out of reset.
`define ACGF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("acgf assertion failed");

`endif

/* src/acgf_pkg.sv */
// Package for the column gap filter: widths, codes, result type.
package acgf_pkg;

  localparam int MAX_COLUMNS  = 65536;
  localparam int COL_W        = $clog2(MAX_COLUMNS);
  localparam int CNT_W        = 13;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int RES_W        = 8;
  localparam int PROD_W       = CNT_W + CFG_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [RES_W-1:0] RES_N   = 8'h4E;
  localparam logic [RES_W-1:0] RES_GAP = 8'h2D;

  localparam logic [CFG_W-1:0] SEQ_COUNT_RST = 13'd1;
  localparam logic [CFG_W-1:0] THR_NUM_RST   = 13'd1;
  localparam logic [CFG_W-1:0] THR_DEN_RST   = 13'd20;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    ACT_COUNT  = 1'b0,
    ACT_FILTER = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEQ_COUNT = 2'd0,
    REG_THR_NUM   = 2'd1,
    REG_THR_DEN   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [RES_W-1:0] kept_residue;
    logic             residue_valid;
    logic             row_done;
  } result_t;

endpackage

/* src/acgf_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module acgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; a read of the entry written at the same edge returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/acgf_out_fifo.sv */
// Small result queue that decouples the filter pipeline from the output stall.
module acgf_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  acgf_pkg::result_t               push_data_i,
  input  logic                            pop_i,
  output acgf_pkg::result_t               head_o,
  output logic                            not_empty_o,
  output logic [acgf_pkg::FIFO_CNT_W-1:0] count_o
);

  acgf_pkg::result_t                entry_q [acgf_pkg::FIFO_DEPTH];
  logic [acgf_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [acgf_pkg::FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [acgf_pkg::FIFO_CNT_W-1:0]  count_q, count_d;

  // Advance pointers with wrap at the last entry
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == acgf_pkg::FIFO_PTR_W'(acgf_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == acgf_pkg::FIFO_PTR_W'(acgf_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // Hold pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o      = entry_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

endmodule

/* src/alignment_column_gap_filter_unit.sv */
// Top level of the alignment column gap filter: column counters and filter pipeline.
//
// Takes one residue per cycle in both passes while in_stall_o is low. A request
// goes through a read stage, where the column counter is read from a 65536 x 13
// synchronous RAM and updated (count pass), and a compare stage, where it is
// multiplied by the denominator and compared (filter pass); a kept residue or a
// row end is then queued and is valid at the output while it heads the queue. A
// result register stands between the RAM read and the multiplier, and a forwarding
// register covers a counter written in the cycle its column is read again. After
// reset the block runs a clearing pass that writes zero to each of the 65536
// counter RAM entries, during which input is stalled; configuration writes are
// taken throughout. The four-entry result queue is credit-managed, so after the
// clearing pass input stalls only when queued and in-flight requests fill it.
`include "assert_macros.svh"

module alignment_column_gap_filter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration port
  input  logic                           cfg_we_i,
  input  logic [acgf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [acgf_pkg::CFG_W-1:0]     cfg_data_i,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [acgf_pkg::RES_W-1:0]     residue_i,
  input  logic                           row_end_i,
  // Output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [acgf_pkg::RES_W-1:0]     kept_residue_o,
  output logic                           residue_valid_o,
  output logic                           row_done_o
);

  // Configuration registers
  logic [acgf_pkg::CFG_W-1:0]  seq_count_q, thr_num_q, thr_den_q;
  logic [acgf_pkg::PROD_W-1:0] rhs_q;

  // Column position and clearing pass
  logic [acgf_pkg::COL_W-1:0]  pos_q, pos_d;
  logic                        clr_active_q;
  logic [acgf_pkg::COL_W-1:0]  clr_addr_q;

  // Read stage
  logic                        s1_valid_q;
  logic                        s1_action_q;
  logic [acgf_pkg::RES_W-1:0]  s1_residue_q;
  logic                        s1_row_end_q;
  logic [acgf_pkg::COL_W-1:0]  s1_addr_q;

  // Forwarding of the write made at the edge of the current read
  logic                        fwd_valid_q;
  logic [acgf_pkg::COL_W-1:0]  fwd_addr_q;
  logic [acgf_pkg::CNT_W-1:0]  fwd_data_q;

  // Compare stage
  logic                        s2_valid_q;
  logic                        s2_action_q;
  logic [acgf_pkg::RES_W-1:0]  s2_residue_q;
  logic                        s2_row_end_q;
  logic [acgf_pkg::CNT_W-1:0]  s2_cnt_q;

  logic                        in_accept;
  logic [acgf_pkg::CNT_W-1:0]  ram_rdata;
  logic                        ram_we;
  logic [acgf_pkg::COL_W-1:0]  ram_waddr;
  logic [acgf_pkg::CNT_W-1:0]  ram_wdata;
  logic [acgf_pkg::CNT_W-1:0]  cnt_cur;
  logic [acgf_pkg::CNT_W-1:0]  cnt_inc;
  logic                        s1_is_bad;
  logic                        cnt_we;
  logic [acgf_pkg::PROD_W-1:0] lhs;
  logic                        keep;
  logic                        push;
  acgf_pkg::result_t           push_data;
  acgf_pkg::result_t           head;
  logic                        fifo_not_empty;
  logic [acgf_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [acgf_pkg::FIFO_CNT_W:0]   inflight;
  logic                        pop;

  // Count requests that still may need a queue entry
  assign inflight = {1'b0, fifo_count}
                  + {{acgf_pkg::FIFO_CNT_W{1'b0}}, s1_valid_q}
                  + {{acgf_pkg::FIFO_CNT_W{1'b0}}, s2_valid_q};

  assign in_stall_o = clr_active_q ||
                      (inflight >= (acgf_pkg::FIFO_CNT_W + 1)'(acgf_pkg::FIFO_DEPTH));
  assign in_accept  = in_valid_i && !in_stall_o;

  // Write configuration; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_count_q <= acgf_pkg::SEQ_COUNT_RST;
      thr_num_q   <= acgf_pkg::THR_NUM_RST;
      thr_den_q   <= acgf_pkg::THR_DEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        acgf_pkg::REG_SEQ_COUNT: seq_count_q <= cfg_data_i;
        acgf_pkg::REG_THR_NUM:   thr_num_q   <= cfg_data_i;
        acgf_pkg::REG_THR_DEN:   thr_den_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Precompute the right-hand side of the keep test
  always_ff @(posedge clk_i) begin
    rhs_q <= acgf_pkg::PROD_W'(thr_num_q) * acgf_pkg::PROD_W'(seq_count_q);
  end

  // Advance the column position, restart after a row end or the last column
  always_comb begin
    pos_d = pos_q;
    if (in_accept) begin
      if (row_end_i ||
          pos_q == acgf_pkg::COL_W'(acgf_pkg::MAX_COLUMNS - 1)) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // Sweep the counter RAM after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      pos_q        <= '0;
    end else begin
      pos_q <= pos_d;
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == acgf_pkg::COL_W'(acgf_pkg::MAX_COLUMNS - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
    end
  end

  // Pick the freshest counter value and its saturating increment
  assign cnt_cur   = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : ram_rdata;
  assign cnt_inc   = (cnt_cur == acgf_pkg::CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign s1_is_bad = (s1_residue_q == acgf_pkg::RES_N) ||
                     (s1_residue_q == acgf_pkg::RES_GAP);
  assign cnt_we    = s1_valid_q && (s1_action_q == acgf_pkg::ACT_COUNT) && s1_is_bad;

  assign ram_we    = clr_active_q || cnt_we;
  assign ram_waddr = clr_active_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_active_q ? '0 : cnt_inc;

  acgf_ram #(
    .WIDTH (acgf_pkg::CNT_W),
    .DEPTH (acgf_pkg::MAX_COLUMNS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // Advance pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_accept;
      s2_valid_q  <= s1_valid_q;
      fwd_valid_q <= cnt_we;
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk_i) begin
    s1_action_q  <= action_i;
    s1_residue_q <= residue_i;
    s1_row_end_q <= row_end_i;
    s1_addr_q    <= pos_q;
    fwd_addr_q   <= s1_addr_q;
    fwd_data_q   <= cnt_inc;
    s2_action_q  <= s1_action_q;
    s2_residue_q <= s1_residue_q;
    s2_row_end_q <= s1_row_end_q;
    s2_cnt_q     <= cnt_cur;
  end

  // Test the column against the threshold and form the result
  assign lhs  = acgf_pkg::PROD_W'(s2_cnt_q) * acgf_pkg::PROD_W'(thr_den_q);
  assign keep = (lhs <= rhs_q);
  assign push = s2_valid_q && (s2_action_q == acgf_pkg::ACT_FILTER) && (keep || s2_row_end_q);

  assign push_data.kept_residue  = keep ? s2_residue_q : '0;
  assign push_data.residue_valid = keep;
  assign push_data.row_done      = s2_row_end_q;

  assign pop = fifo_not_empty && !out_stall_i;

  acgf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (fifo_not_empty),
    .count_o     (fifo_count)
  );

  assign out_valid_o     = fifo_not_empty;
  assign kept_residue_o  = head.kept_residue;
  assign residue_valid_o = head.residue_valid;
  assign row_done_o      = head.row_done;

  // Queue credit never overruns, drops carry a row end, clearing writes zeros
  `ACGF_ASSERT_ALWAYS(a_credit_bound, clk_i, rst_ni,
    inflight <= (acgf_pkg::FIFO_CNT_W + 1)'(acgf_pkg::FIFO_DEPTH))
  `ACGF_ASSERT_IMP(a_drop_is_row_end, clk_i, rst_ni,
    out_valid_o && !residue_valid_o, row_done_o && (kept_residue_o == '0))
  `ACGF_ASSERT_IMP(a_clear_writes_zero, clk_i, rst_ni,
    clr_active_q, ram_we && (ram_wdata == '0) && !s1_valid_q)

endmodule

/* test/tb_alignment_column_gap_filter_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the alignment column gap filter unit.
module tb_alignment_column_gap_filter_unit;
  import acgf_pkg::*;

  localparam int PIPE_LATENCY   = 3;
  localparam int SETTLE_CYCLES  = PIPE_LATENCY + 5;
  // clearing pass after reset plus the longest stalls, taken several times over
  localparam int WATCHDOG_LIMIT = 4 * MAX_COLUMNS;
  localparam int RANDOM_ITEMS   = 1360;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0]     CFG_FULL   = {CFG_W{1'b1}};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 action_i    = 1'b0;
  logic [RES_W-1:0]     residue_i   = '0;
  logic                 row_end_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [RES_W-1:0]     kept_residue_o;
  logic                 residue_valid_o;
  logic                 row_done_o;

  // Scoreboard copy of the column counters, position and thresholds
  logic [CNT_W-1:0] gap_count [MAX_COLUMNS];
  logic [COL_W-1:0] column_idx;
  logic [CFG_W-1:0] seq_count_r;
  logic [CFG_W-1:0] thr_num_r;
  logic [CFG_W-1:0] thr_den_r;
  result_t          filtered_residues [$];
  int               mismatches  = 0;
  int               idle_cycles = 0;
  bit               quiet_mode  = 1'b0;

  alignment_column_gap_filter_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .residue_i       (residue_i),
    .row_end_i       (row_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kept_residue_o  (kept_residue_o),
    .residue_valid_o (residue_valid_o),
    .row_done_o      (row_done_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_mode || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Residue whose chance of being N or gap depends on its column
  function automatic logic [RES_W-1:0] pick_residue(int col);
    if ($urandom_range(0, 99) < (col * 37) % 70) begin
      return $urandom_range(0, 1) ? RES_N : RES_GAP;
    end
    return RES_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_W-1:0] pick_corner();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(4096);
      default: return CFG_FULL;
    endcase
  endfunction

  // Count or filter one residue and queue the result it gives, if any
  function automatic void filter_and_count(action_e act, logic [RES_W-1:0] res, logic row_end);
    logic [PROD_W-1:0] weighted;
    logic [PROD_W-1:0] allowed;
    logic              keep;
    result_t           item;
    if (act == ACT_COUNT) begin
      if ((res == RES_N || res == RES_GAP) && gap_count[column_idx] != CNT_MAX) begin
        gap_count[column_idx] = gap_count[column_idx] + 1'b1;
      end
    end else begin
      weighted = PROD_W'(gap_count[column_idx]) * PROD_W'(thr_den_r);
      allowed  = PROD_W'(thr_num_r) * PROD_W'(seq_count_r);
      keep     = (weighted <= allowed);
      if (keep || row_end) begin
        item.kept_residue  = keep ? res : '0;
        item.residue_valid = keep;
        item.row_done      = row_end;
        filtered_residues = {filtered_residues, item};
      end
    end
    column_idx = row_end ? '0 : column_idx + 1'b1;
  endfunction

  // Offer one request after a random gap; hold it until taken
  task automatic send_residue(input action_e act, input logic [RES_W-1:0] res,
                              input logic row_end);
    int gap;
    gap = pick_idle_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    residue_i  <= res;
    row_end_i  <= row_end;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    filter_and_count(act, res, row_end);
  endtask

  task automatic send_row(input action_e act, input int len);
    for (int c = 0; c < len; c++) begin
      send_residue(act, pick_residue(c), c == len - 1);
    end
  endtask

  // Hold input, let every result drain and the pipeline empty
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (filtered_residues.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      REG_SEQ_COUNT: seq_count_r = value;
      REG_THR_NUM:   thr_num_r   = value;
      REG_THR_DEN:   thr_den_r   = value;
      default: ;
    endcase
  endtask

  task automatic apply_thresholds(input logic [CFG_W-1:0] seq, input logic [CFG_W-1:0] num,
                                  input logic [CFG_W-1:0] den);
    set_register(REG_SEQ_COUNT, seq);
    set_register(REG_THR_NUM, num);
    set_register(REG_THR_DEN, den);
    cfg_we_i <= 1'b0;
  endtask

  // Reset thresholds: a column passes only while its count is zero
  task automatic test_default_thresholds();
    // count pass; lower-case n must not count
    send_residue(ACT_COUNT, RES_N, 1'b0);
    send_residue(ACT_COUNT, RES_GAP, 1'b0);
    send_residue(ACT_COUNT, "n", 1'b0);
    send_residue(ACT_COUNT, 8'hFF, 1'b1);
    // filter pass: drop bad columns, keep clean ones and the row end
    send_residue(ACT_FILTER, "A", 1'b0);
    send_residue(ACT_FILTER, "C", 1'b0);
    send_residue(ACT_FILTER, 8'h00, 1'b0);
    send_residue(ACT_FILTER, 8'hFF, 1'b1);
    // dropped residue on a row end still reports the row end
    send_residue(ACT_FILTER, "G", 1'b0);
    send_residue(ACT_FILTER, "T", 1'b1);
    // change of pass mid-row leaves the column advancing
    send_residue(ACT_COUNT, RES_GAP, 1'b0);
    send_residue(ACT_FILTER, RES_N, 1'b0);
    send_residue(ACT_COUNT, RES_N, 1'b0);
    send_residue(ACT_FILTER, "A", 1'b1);
  endtask

  // Zero and full-scale register values, and a write to an unused index
  task automatic test_register_corners();
    settle_block();
    apply_thresholds('0, CFG_W'(5), CFG_W'(3));
    send_row(ACT_FILTER, 4);
    settle_block();
    apply_thresholds(CFG_W'(100), '0, CFG_W'(7));
    send_row(ACT_FILTER, 4);
    settle_block();
    apply_thresholds(CFG_W'(1), '0, '0);
    send_row(ACT_FILTER, 3);
    settle_block();
    set_register(REG_UNUSED, CFG_FULL);
    cfg_we_i <= 1'b0;
    send_row(ACT_FILTER, 3);
    settle_block();
    apply_thresholds(CFG_FULL, CFG_FULL, CFG_FULL);
    send_row(ACT_FILTER, 2);
  endtask

  // Count-then-filter phases under varied thresholds, with some noise
  task automatic test_random_passes();
    int               sent;
    int               rows;
    int               len;
    int               noise;
    logic [CFG_W-1:0] seq;
    logic [CFG_W-1:0] num;
    logic [CFG_W-1:0] den;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_block();
      case ($urandom_range(0, 5))
        0: begin
          seq = pick_corner();
          num = pick_corner();
          den = pick_corner();
        end
        1: begin
          seq = CFG_W'($urandom_range(0, 8191));
          num = CFG_W'($urandom_range(0, 8191));
          den = CFG_W'($urandom_range(0, 8191));
        end
        default: begin
          seq = CFG_W'($urandom_range(1, 64));
          den = CFG_W'($urandom_range(1, 20));
          num = CFG_W'($urandom_range(0, den));
        end
      endcase
      apply_thresholds(seq, num, den);
      quiet_mode = ($urandom_range(0, 4) == 0);
      rows = $urandom_range(1, 12);
      len  = $urandom_range(1, 24);
      if ($urandom_range(0, 9) == 0) begin
        len  = $urandom_range(100, 300);
        rows = $urandom_range(1, 2);
      end
      // keep the total close to the item budget
      while (rows > 1 && 2 * rows * len > RANDOM_ITEMS - sent) rows--;
      if (2 * len > RANDOM_ITEMS - sent) len = (RANDOM_ITEMS - sent + 1) / 2;
      repeat (rows) send_row(ACT_COUNT, len);
      // now and then let everything drain between the passes
      if ($urandom_range(0, 7) == 0) settle_block();
      repeat (rows) send_row(ACT_FILTER, len);
      sent += 2 * rows * len;
      // broken rows: mixed passes and stray row ends
      if ($urandom_range(0, 3) == 0) begin
        noise = $urandom_range(1, 20);
        repeat (noise) begin
          send_residue(action_e'($urandom_range(0, 1)), RES_W'($urandom_range(0, 255)),
                       $urandom_range(0, 5) == 0);
        end
        sent += noise;
      end
    end
    quiet_mode = 1'b0;
  endtask

  // Stall the output in random bursts
  initial begin : drive_out_stall
    int hold;
    @(posedge clk_i);
    forever begin
      hold = pick_idle_length();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (filtered_residues.size() == 0) begin
        $display("%0t: result with none expected: kept_residue %h residue_valid %b row_done %b",
                 $time, kept_residue_o, residue_valid_o, row_done_o);
        mismatches++;
      end else begin
        want = filtered_residues.pop_front();
        if (kept_residue_o !== want.kept_residue) begin
          $display("%0t: kept_residue expected %h actual %h",
                   $time, want.kept_residue, kept_residue_o);
          mismatches++;
        end
        if (residue_valid_o !== want.residue_valid) begin
          $display("%0t: residue_valid expected %b actual %b",
                   $time, want.residue_valid, residue_valid_o);
          mismatches++;
        end
        if (row_done_o !== want.row_done) begin
          $display("%0t: row_done expected %b actual %b", $time, want.row_done, row_done_o);
          mismatches++;
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, filtered_residues.size());
      $display("[alignment_column_gap_filter_unit] ERROR");
      $finish;
    end
  end

  initial begin : run_tests
    foreach (gap_count[c]) gap_count[c] = '0;
    column_idx  = '0;
    seq_count_r = SEQ_COUNT_RST;
    thr_num_r   = THR_NUM_RST;
    thr_den_r   = THR_DEN_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_thresholds();
    test_register_corners();
    test_random_passes();
    settle_block();
    if (mismatches == 0 && filtered_residues.size() == 0) begin
      $display("[alignment_column_gap_filter_unit] OK");
    end else begin
      $display("[alignment_column_gap_filter_unit] ERROR");
    end
    $finish;
  end

endmodule

/* alignment_column_gap_filter_unit.f */
+incdir+src
src/acgf_pkg.sv
src/acgf_ram.sv
src/acgf_out_fifo.sv
src/alignment_column_gap_filter_unit.sv
test/tb_alignment_column_gap_filter_unit.sv
